@@ design/anb_pkg.sv @@
// Package for the Annex-B to length-prefixed converter.
// Holds the channel payload types, the front-to-back event type and the codes.
// No dependencies.
package anb_pkg;

   localparam int unsigned MAX_UNIT_BYTES      = 1048576;
   localparam int unsigned SAMPLE_BUFFER_BYTES = 1049600;

   localparam int unsigned POS_W  = 21;
   localparam int unsigned OFF_W  = 20;
   localparam int unsigned LEN_W  = 21;
   localparam int unsigned SUM_W  = LEN_W + 1;
   localparam int unsigned DUR_W  = 20;
   localparam int unsigned CFG_W  = 17;

   localparam logic [POS_W-1:0] MAX_UNIT   = POS_W'(MAX_UNIT_BYTES);
   localparam logic [SUM_W-1:0] SAMPLE_CAP = SUM_W'(SAMPLE_BUFFER_BYTES);
   localparam logic [SUM_W-1:0] PREFIX_LEN = SUM_W'(4);

   localparam logic [CFG_W-1:0] DEFAULT_DURATION_RESET = CFG_W'(3000);

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [2:0] KIND_NAL     = 3'd0;
   localparam logic [2:0] KIND_SAMPLE  = 3'd1;
   localparam logic [2:0] KIND_EMPTY   = 3'd2;
   localparam logic [2:0] KIND_DROPPED = 3'd3;
   localparam logic [2:0] KIND_ERROR   = 3'd4;

   localparam logic [1:0] ACT_APPEND = 2'd0;
   localparam logic [1:0] ACT_SPS    = 2'd1;
   localparam logic [1:0] ACT_PPS    = 2'd2;
   localparam logic [1:0] ACT_SKIP   = 2'd3;

   localparam logic [4:0] NAL_IDR    = 5'd5;
   localparam logic [4:0] NAL_SPS    = 5'd7;
   localparam logic [4:0] NAL_PPS    = 5'd8;
   localparam logic [4:0] NAL_AUD    = 5'd9;
   localparam logic [4:0] NAL_FILLER = 5'd12;

   localparam logic FUNC_BYTE    = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   typedef struct packed {
      logic             func;
      logic [7:0]       data_byte;
      logic             last_byte;
      logic [DUR_W-1:0] duration;
   } req_type;

   typedef struct packed {
      logic [2:0]       kind;
      logic [OFF_W-1:0] nal_offset;
      logic [LEN_W-1:0] nal_length;
      logic [4:0]       nal_code;
      logic [1:0]       nal_action;
      logic [LEN_W-1:0] sample_length;
      logic             random_access;
      logic [DUR_W-1:0] sample_duration;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic             restart;
      logic             overlong;
      logic             close;
      logic             last;
      logic [OFF_W-1:0] nal_offset;
      logic [LEN_W-1:0] nal_length;
      logic [4:0]       nal_code;
      logic [DUR_W-1:0] duration;
   } evt_type;

endpackage

@@ design/anb_front.sv @@
// Front end: start-code scan, NAL boundary tracking and event classification.
// Depends on anb_pkg.
module anb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  anb_pkg::req_type req,
   output logic             push,
   output anb_pkg::evt_type evt
);

   logic [anb_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [1:0]                zero_run_ff, zero_run_in;
   logic                      inside_ff, inside_in;
   logic [anb_pkg::POS_W-1:0] nal_start_ff, nal_start_in;
   logic [anb_pkg::POS_W-1:0] content_end_ff, content_end_in;
   logic [4:0]                htype_ff, htype_in;

   logic                      overlong;
   logic                      scode;
   logic [anb_pkg::POS_W-1:0] pos_inc;

   assign overlong = pos_ff >= anb_pkg::MAX_UNIT;
   assign scode    = (zero_run_ff >= 2'd2) && (req.data_byte == 8'd1);
   assign pos_inc  = pos_ff + anb_pkg::POS_W'(1);

   always_comb begin
      pos_in         = pos_ff;
      zero_run_in    = zero_run_ff;
      inside_in      = inside_ff;
      nal_start_in   = nal_start_ff;
      content_end_in = content_end_ff;
      htype_in       = htype_ff;
      evt            = '0;
      push           = 1'b0;
      if (accept) begin
         if (req.func == anb_pkg::FUNC_RESTART) begin
            pos_in         = '0;
            zero_run_in    = '0;
            inside_in      = 1'b0;
            nal_start_in   = '0;
            content_end_in = '0;
            htype_in       = '0;
            evt.restart    = 1'b1;
         end else begin
            if (!overlong) begin
               pos_in = pos_inc;
            end
            if (overlong) begin
               evt.overlong = 1'b1;
            end else if (scode) begin
               evt.close      = inside_ff && (content_end_ff > nal_start_ff);
               evt.nal_offset = nal_start_ff[anb_pkg::OFF_W-1:0];
               evt.nal_length = content_end_ff - nal_start_ff;
               evt.nal_code   = htype_ff;
               inside_in      = 1'b1;
               nal_start_in   = pos_inc;
               content_end_in = pos_inc;
               htype_in       = '0;
               zero_run_in    = '0;
            end else begin
               if (inside_ff) begin
                  if (pos_ff == nal_start_ff) begin
                     htype_in = req.data_byte[4:0];
                  end
                  if (req.data_byte != 8'd0) begin
                     content_end_in = pos_inc;
                  end
               end
               if (req.data_byte == 8'd0) begin
                  zero_run_in = (zero_run_ff >= 2'd2) ? 2'd2 : zero_run_ff + 2'd1;
               end else begin
                  zero_run_in = '0;
               end
               if (req.last_byte) begin
                  evt.close      = inside_ff && (content_end_in > nal_start_ff);
                  evt.nal_offset = nal_start_ff[anb_pkg::OFF_W-1:0];
                  evt.nal_length = content_end_in - nal_start_ff;
                  evt.nal_code   = htype_in;
               end
            end
            evt.last     = req.last_byte;
            evt.duration = req.duration;
            if (req.last_byte) begin
               pos_in         = '0;
               zero_run_in    = '0;
               inside_in      = 1'b0;
               nal_start_in   = '0;
               content_end_in = '0;
               htype_in       = '0;
            end
         end
         push = evt.restart | evt.overlong | evt.close | evt.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         zero_run_ff    <= '0;
         inside_ff      <= 1'b0;
         nal_start_ff   <= '0;
         content_end_ff <= '0;
         htype_ff       <= '0;
      end else begin
         pos_ff         <= pos_in;
         zero_run_ff    <= zero_run_in;
         inside_ff      <= inside_in;
         nal_start_ff   <= nal_start_in;
         content_end_ff <= content_end_in;
         htype_ff       <= htype_in;
      end
   end

endmodule

@@ design/anb_fifo.sv @@
// Event queue between the front end and the back end.
// Depends on anb_pkg.
module anb_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  anb_pkg::evt_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output anb_pkg::evt_type head
);

   anb_pkg::evt_type            mem_ff [anb_pkg::FIFO_DEPTH];
   logic [anb_pkg::FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [anb_pkg::FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [anb_pkg::FIFO_AW:0]   count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign full      = count_ff == (anb_pkg::FIFO_AW+1)'(anb_pkg::FIFO_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + anb_pkg::FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + anb_pkg::FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (anb_pkg::FIFO_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (anb_pkg::FIFO_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/anb_back.sv @@
// Back end: sample accounting, SPS/PPS registration, error tracking and result register.
// Depends on anb_pkg.
module anb_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      evt_valid,
   input  anb_pkg::evt_type          evt,
   output logic                      pop,
   input  logic                      csr_write,
   input  logic [anb_pkg::CFG_W-1:0] csr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output anb_pkg::rsp_type          rsp_data
);

   typedef enum logic [1:0] {
      ST_EVENT = 2'b01,
      ST_CLOSE = 2'b10
   } state_type;

   state_type                 state_ff, state_in;
   logic [anb_pkg::LEN_W-1:0] acc_ff, acc_in;
   logic                      idr_ff, idr_in;
   logic                      sps_ff, sps_in;
   logic                      pps_ff, pps_in;
   logic                      failed_ff, failed_in;
   logic                      sticky_ff, sticky_in;
   logic [anb_pkg::CFG_W-1:0] dflt_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   anb_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   logic                      slot_free;
   logic [anb_pkg::SUM_W-1:0] sum;
   logic                      fail_now;
   logic                      rec;
   logic                      overflow;
   logic [1:0]                act;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign sum = {1'b0, acc_ff} + anb_pkg::PREFIX_LEN + {1'b0, evt.nal_length};

   function automatic anb_pkg::rsp_type closing(
      input logic                      failed,
      input logic [anb_pkg::LEN_W-1:0] acc,
      input logic                      idr,
      input logic                      sps,
      input logic                      pps,
      input logic [anb_pkg::DUR_W-1:0] dur,
      input logic [anb_pkg::CFG_W-1:0] dflt
   );
      anb_pkg::rsp_type r;
      r      = '0;
      r.last = 1'b1;
      if (failed) begin
         r.kind = anb_pkg::KIND_ERROR;
      end else if (acc == '0) begin
         r.kind = anb_pkg::KIND_EMPTY;
      end else if (!sps || !pps) begin
         r.kind = anb_pkg::KIND_DROPPED;
      end else begin
         r.kind            = anb_pkg::KIND_SAMPLE;
         r.sample_length   = acc;
         r.random_access   = idr;
         r.sample_duration = (dur != '0) ? dur : anb_pkg::DUR_W'(dflt);
      end
      return r;
   endfunction

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      idr_in       = idr_ff;
      sps_in       = sps_ff;
      pps_in       = pps_ff;
      failed_in    = failed_ff;
      sticky_in    = sticky_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      fail_now     = failed_ff | sticky_ff | evt.overlong;
      rec          = 1'b0;
      overflow     = 1'b0;
      act          = anb_pkg::ACT_APPEND;

      if (slot_free) begin
         rsp_valid_in = 1'b0;
      end

      if (slot_free && evt_valid) begin
         case (state_ff)
            ST_EVENT: begin
               if (evt.restart) begin
                  acc_in    = '0;
                  idr_in    = 1'b0;
                  sps_in    = 1'b0;
                  pps_in    = 1'b0;
                  failed_in = 1'b0;
                  sticky_in = 1'b0;
                  pop       = 1'b1;
               end else begin
                  if (evt.close && !fail_now) begin
                     if (evt.nal_code == anb_pkg::NAL_SPS) begin
                        act    = sps_ff ? anb_pkg::ACT_SKIP : anb_pkg::ACT_SPS;
                        sps_in = 1'b1;
                        rec    = 1'b1;
                     end else if (evt.nal_code == anb_pkg::NAL_PPS) begin
                        act    = pps_ff ? anb_pkg::ACT_SKIP : anb_pkg::ACT_PPS;
                        pps_in = 1'b1;
                        rec    = 1'b1;
                     end else if (evt.nal_code == anb_pkg::NAL_AUD ||
                                  evt.nal_code == anb_pkg::NAL_FILLER) begin
                        act = anb_pkg::ACT_SKIP;
                        rec = 1'b1;
                     end else if (sum > anb_pkg::SAMPLE_CAP) begin
                        overflow = 1'b1;
                     end else begin
                        acc_in = sum[anb_pkg::LEN_W-1:0];
                        idr_in = idr_ff | (evt.nal_code == anb_pkg::NAL_IDR);
                        rec    = 1'b1;
                     end
                  end
                  if (fail_now || overflow) begin
                     failed_in = 1'b1;
                     sticky_in = 1'b1;
                  end
                  if (rec) begin
                     rsp_valid_in              = 1'b1;
                     rsp_data_in               = '0;
                     rsp_data_in.kind          = anb_pkg::KIND_NAL;
                     rsp_data_in.nal_offset    = evt.nal_offset;
                     rsp_data_in.nal_length    = evt.nal_length;
                     rsp_data_in.nal_code      = evt.nal_code;
                     rsp_data_in.nal_action    = act;
                     rsp_data_in.sample_length = acc_in;
                     rsp_data_in.random_access = idr_in;
                     rsp_data_in.last          = !evt.last;
                     if (evt.last) begin
                        state_in = ST_CLOSE;
                     end else begin
                        pop = 1'b1;
                     end
                  end else begin
                     pop = 1'b1;
                     if (evt.last) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = closing(fail_now | overflow, acc_in, idr_in,
                                               sps_in, pps_in, evt.duration, dflt_ff);
                        acc_in       = '0;
                        idr_in       = 1'b0;
                        failed_in    = 1'b0;
                     end
                  end
               end
            end
            ST_CLOSE: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = closing(failed_ff | sticky_ff, acc_ff, idr_ff, sps_ff,
                                      pps_ff, evt.duration, dflt_ff);
               acc_in       = '0;
               idr_in       = 1'b0;
               failed_in    = 1'b0;
               pop          = 1'b1;
               state_in     = ST_EVENT;
            end
            default: begin
               state_in = ST_EVENT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_EVENT;
         acc_ff       <= '0;
         idr_ff       <= 1'b0;
         sps_ff       <= 1'b0;
         pps_ff       <= 1'b0;
         failed_ff    <= 1'b0;
         sticky_ff    <= 1'b0;
         dflt_ff      <= anb_pkg::DEFAULT_DURATION_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         idr_ff       <= idr_in;
         sps_ff       <= sps_in;
         pps_ff       <= pps_in;
         failed_ff    <= failed_in;
         sticky_ff    <= sticky_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            dflt_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ design/annexb_nal_length_prefix_converter_core.sv @@
// Top level of the Annex-B to length-prefixed sample converter.
// Instantiates anb_front, anb_fifo and anb_back; depends on anb_pkg.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  anb_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall  anb_pkg::rsp_type
//   csr      in         csr_valid/csr_ready  default duration, 17 bits
//
// One byte is accepted per cycle while the four-entry event queue has room.
// The back end retires one event per cycle unless rsp_stall holds it; a NAL
// closed on a unit's last byte gives its record in ST_EVENT and the closing
// result in ST_CLOSE. Results leave through a single output register; reset is
// synchronous and clears all unit state, parameter-set flags and error flags.
// req_stall is the queue-full flag; rsp_stall holds the output register.
module annexb_nal_length_prefix_converter_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  anb_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output anb_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [anb_pkg::CFG_W-1:0] csr_data
);

   logic             accept;
   logic             push;
   anb_pkg::evt_type push_evt;
   logic             full;
   logic             pop;
   logic             not_empty;
   anb_pkg::evt_type head;

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign csr_ready = 1'b1;

   anb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .push   (push),
      .evt    (push_evt)
   );

   anb_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_evt),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   anb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .evt_valid (not_empty),
      .evt       (head),
      .pop       (pop),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/anb_checker.sv @@
// Port-level checks for the converter top level, attached by bind.
// Depends on anb_pkg and annexb_nal_length_prefix_converter_core.
module anb_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input anb_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_close_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != anb_pkg::KIND_NAL |->
         rsp_data.last && rsp_data.nal_length == '0 && rsp_data.nal_offset == '0)
      else $error("closing result malformed");

   a_nal_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == anb_pkg::KIND_NAL |->
         rsp_data.nal_length != '0 && rsp_data.sample_duration == '0)
      else $error("NAL record malformed");

   a_sample_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == anb_pkg::KIND_SAMPLE |->
         rsp_data.sample_length >= anb_pkg::LEN_W'(5))
      else $error("sample ready without content");

endmodule

bind annexb_nal_length_prefix_converter_core anb_checker u_anb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
